[sv/arik_pkg.sv]
// Shared types, codes and constants of the arm reach inverse kinematics block.
package arik_pkg;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_HIGH = 2'd1;
  localparam logic [1:0] STATUS_LOW  = 2'd2;

  localparam logic [1:0] REGION_ABOVE = 2'd0;
  localparam logic [1:0] REGION_MID   = 2'd1;
  localparam logic [1:0] REGION_BELOW = 2'd2;

  localparam logic [0:0] REG_MIN_GRASP = 1'd0;
  localparam logic [0:0] REG_MAX_GRASP = 1'd1;

  // Arm geometry in 0.1 mm units.
  localparam logic signed [19:0] ELBOW_Z    = 20'sd6700;
  localparam logic signed [19:0] ELBOW_LOW  = 20'sd5460;
  localparam logic signed [19:0] SHOULDER_Z = 20'sd5220;
  localparam logic signed [19:0] WRIST_LOW  = 20'sd4980;
  localparam logic signed [19:0] FOREARM    = 20'sd1500;
  localparam logic [21:0]        FOREARM_SQ = 22'd2250000;
  localparam logic signed [12:0] BASE_REACH = 13'sd1460;

  localparam int QUEUE_DEPTH = 4;
  localparam int SQRT_IN_W   = 54;
  localparam int SQRT_ROOT_W = SQRT_IN_W / 2;
  localparam int CORDIC_W    = 38;
  localparam int ANGLE_W     = 34;

  localparam logic signed [ANGLE_W-1:0] Q30_PI      = 34'sd3373259426;
  localparam longint                    Q30_HALF_PI = 64'sd1686629713;

  localparam logic [29:0] ATAN_Q30 [24] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         region;
    logic signed [11:0] d;
    logic signed [19:0] x;
    logic signed [19:0] y;
  } arik_item_t;

endpackage

[sv/arm_reach_inverse_kinematics.sv]
// Arm reach inverse kinematics: target point to joint angles, base turn and drive.
//
// Input channel (in_valid_i / in_ready_o) takes a target point and a correction
// offset in 0.1 mm units; each transfer yields exactly one result on the output
// channel (out_valid_o / out_ready_i), in order. The result gives a status, the
// height region, the shoulder, elbow and wrist angles and the base rotation in
// 2^-ANGLE_FRAC_BITS rad, and the drive distance in 0.1 mm.
// The grasp height limits sit on the APB port at byte addresses 0 and 4.
// A transfer goes into a four-entry queue; the solver pipeline behind it holds
// two square-root units (27 stages) and three CORDIC units (CORDIC_STEPS + 1
// stages). One transfer is taken every cycle while the output is drained.
// When the receiver stalls, the whole solver pipeline holds; the queue keeps
// taking items until its four entries are full, then in_ready_o falls.
// Reset empties the queue and pipeline and sets the limits to 3500 and 8000.
module arm_reach_inverse_kinematics #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [18:0] target_x_i,
  input  logic [18:0] target_y_i,
  input  logic [18:0] target_z_i,
  input  logic [18:0] offset_x_i,
  input  logic [18:0] offset_y_i,
  input  logic [18:0] offset_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  height_region_o,
  output logic [15:0] shoulder_angle_o,
  output logic [15:0] elbow_angle_o,
  output logic [15:0] wrist_angle_o,
  output logic [15:0] base_rotation_o,
  output logic [19:0] drive_distance_o
);
  import arik_pkg::*;

  logic [14:0] min_grasp_q, max_grasp_q;
  logic        cfg_write;
  logic [0:0]  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_grasp_q <= 15'd3500;
      max_grasp_q <= 15'd8000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_GRASP: min_grasp_q <= pwdata[14:0];
        REG_MAX_GRASP: max_grasp_q <= pwdata[14:0];
        default:       min_grasp_q <= min_grasp_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_MIN_GRASP: prdata = {17'b0, min_grasp_q};
      REG_MAX_GRASP: prdata = {17'b0, max_grasp_q};
      default:       prdata = '0;
    endcase
  end

  logic       push, pop, full, empty;
  arik_item_t push_item, head_item;

  arik_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .target_x_i  (target_x_i),
    .target_y_i  (target_y_i),
    .target_z_i  (target_z_i),
    .offset_x_i  (offset_x_i),
    .offset_y_i  (offset_y_i),
    .offset_z_i  (offset_z_i),
    .min_grasp_i (min_grasp_q),
    .max_grasp_i (max_grasp_q),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  arik_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (head_item)
  );

  arik_back #(
    .AngleFracBits (ANGLE_FRAC_BITS),
    .CordicSteps   (CORDIC_STEPS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .item_i           (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .height_region_o  (height_region_o),
    .shoulder_angle_o (shoulder_angle_o),
    .elbow_angle_o    (elbow_angle_o),
    .wrist_angle_o    (wrist_angle_o),
    .base_rotation_o  (base_rotation_o),
    .drive_distance_o (drive_distance_o)
  );

endmodule

[sv/arik_front.sv]
// Front end: adds the offset, checks the grasp limits and picks the height region.
module arik_front (
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [18:0]             target_x_i,
  input  logic [18:0]             target_y_i,
  input  logic [18:0]             target_z_i,
  input  logic [18:0]             offset_x_i,
  input  logic [18:0]             offset_y_i,
  input  logic [18:0]             offset_z_i,
  input  logic [14:0]             min_grasp_i,
  input  logic [14:0]             max_grasp_i,
  input  logic                    full_i,
  output logic                    push_o,
  output arik_pkg::arik_item_t    item_o
);
  import arik_pkg::*;

  logic signed [19:0] x, y, z, diff;

  assign x = $signed({target_x_i[18], target_x_i}) + $signed({offset_x_i[18], offset_x_i});
  assign y = $signed({target_y_i[18], target_y_i}) + $signed({offset_y_i[18], offset_y_i});
  assign z = $signed({target_z_i[18], target_z_i}) + $signed({offset_z_i[18], offset_z_i});

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o = '0;
    item_o.x = x;
    item_o.y = y;
    if (z > $signed({5'b0, max_grasp_i})) begin
      item_o.status = STATUS_HIGH;
    end else if (z < $signed({5'b0, min_grasp_i})) begin
      item_o.status = STATUS_LOW;
    end else begin
      item_o.status = STATUS_OK;
    end
    if (z > ELBOW_LOW) begin
      item_o.region = REGION_ABOVE;
      diff = z - ELBOW_Z;
    end else if (z >= SHOULDER_Z) begin
      item_o.region = REGION_MID;
      diff = ELBOW_Z - z;
    end else begin
      item_o.region = REGION_BELOW;
      diff = WRIST_LOW - z;
    end
    // The height offset never exceeds the forearm length.
    if (diff > FOREARM) begin
      item_o.d = FOREARM[11:0];
    end else if (diff < -FOREARM) begin
      item_o.d = 12'(-FOREARM);
    end else begin
      item_o.d = diff[11:0];
    end
  end

endmodule

[sv/arik_fifo.sv]
// Short queue of classified items between the front end and the solver.
module arik_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  arik_pkg::arik_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output arik_pkg::arik_item_t item_o
);
  import arik_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  arik_item_t      mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[sv/arik_sqrt.sv]
// Pipelined digit-by-digit square root, one root bit per stage, with remainder.
module arik_sqrt (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [arik_pkg::SQRT_IN_W-1:0]  n_i,
  output logic [arik_pkg::SQRT_ROOT_W-1:0] root_o,
  output logic [arik_pkg::SQRT_ROOT_W+1:0] rem_o
);
  import arik_pkg::*;

  localparam int RW   = SQRT_ROOT_W;
  localparam int RemW = RW + 2;

  logic [RemW-1:0]      rem_q  [RW];
  logic [RW-1:0]        root_q [RW];
  logic [SQRT_IN_W-1:0] n_q    [RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RemW-1:0]      rem_in, rem_x, trial;
    logic [RW-1:0]        root_in;
    logic [SQRT_IN_W-1:0] n_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = n_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign n_in    = n_q[k-1];
    end

    assign rem_x = {rem_in[RemW-3:0], n_in[SQRT_IN_W-1:SQRT_IN_W-2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_x >= trial) begin
          rem_q[k]  <= rem_x - trial;
          root_q[k] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_x;
          root_q[k] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end

    if (k < RW - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_q[k] <= {n_in[SQRT_IN_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[RW-1];
  assign rem_o  = rem_q[RW-1];

endmodule

[sv/arik_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) in Q30 radians.
module arik_cordic #(
  parameter int Steps = 16
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [arik_pkg::CORDIC_W-1:0] x_i,
  input  logic signed [arik_pkg::CORDIC_W-1:0] y_i,
  output logic signed [arik_pkg::ANGLE_W-1:0]  z_o
);
  import arik_pkg::*;

  logic signed [CORDIC_W-1:0] x_q [Steps+1];
  logic signed [CORDIC_W-1:0] y_q [Steps+1];
  logic signed [ANGLE_W-1:0]  z_q [Steps+1];
  logic                       zero_q [Steps+1];

  // Vectors in the left half plane are turned by half a revolution first.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? Q30_PI : -Q30_PI;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ANGLE_W-1:0]  step_angle;

    assign dx         = x_q[k] >>> k;
    assign dy         = y_q[k] >>> k;
    assign step_angle = $signed({{(ANGLE_W-30){1'b0}}, ATAN_Q30[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[k+1] <= zero_q[k];
        if (y_q[k] < 0) begin
          x_q[k+1] <= x_q[k] - dy;
          y_q[k+1] <= y_q[k] + dx;
          z_q[k+1] <= z_q[k] - step_angle;
        end else begin
          x_q[k+1] <= x_q[k] + dy;
          y_q[k+1] <= y_q[k] - dx;
          z_q[k+1] <= z_q[k] + step_angle;
        end
      end
    end
  end

  assign z_o = zero_q[Steps] ? '0 : z_q[Steps];

endmodule

[sv/arik_back.sv]
// Solver: square roots, CORDIC angles, drive distance and the output register.
module arik_back #(
  parameter int AngleFracBits = 13,
  parameter int CordicSteps   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  arik_pkg::arik_item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [1:0]           height_region_o,
  output logic [15:0]          shoulder_angle_o,
  output logic [15:0]          elbow_angle_o,
  output logic [15:0]          wrist_angle_o,
  output logic [15:0]          base_rotation_o,
  output logic [19:0]          drive_distance_o
);
  import arik_pkg::*;

  localparam int Sh = 30 - AngleFracBits;
  localparam logic [ANGLE_W:0] RoundHalf = (ANGLE_W+1)'(1) << (Sh - 1);
  localparam longint ShoulderRaw = (-Q30_HALF_PI + (64'sd1 <<< (Sh - 1))) >>> Sh;
  localparam logic [15:0] ShoulderAngle = ShoulderRaw[15:0];

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  region;
    logic [19:0] drive;
  } arik_tail_t;

  function automatic logic [15:0] to_angle(logic signed [ANGLE_W-1:0] z);
    logic signed [ANGLE_W:0] t;
    logic signed [ANGLE_W:0] s;
    t = $signed({z[ANGLE_W-1], z}) + $signed(RoundHalf);
    s = t >>> Sh;
    return s[15:0];
  endfunction

  logic adv;
  logic out_valid_q;

  // The whole solver pipeline moves when the output register can take a result.
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  // Squares.
  logic               m_valid_q;
  arik_item_t         m_item_q;
  logic [21:0]        arm_n_q;
  logic [39:0]        range_n_q;
  logic signed [23:0] d_sq;
  logic signed [39:0] x_sq, y_sq;
  logic [39:0]        range_sum;

  assign d_sq      = item_i.d * item_i.d;
  assign x_sq      = item_i.x * item_i.x;
  assign y_sq      = item_i.y * item_i.y;
  assign range_sum = x_sq + y_sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_item_q  <= item_i;
      arm_n_q   <= FOREARM_SQ - d_sq[21:0];
      range_n_q <= range_sum;
    end
  end

  // Square roots.
  logic [SQRT_ROOT_W-1:0] arm_root, range_root;
  logic [SQRT_ROOT_W+1:0] arm_rem, range_rem;

  arik_sqrt u_arm_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .n_i    ({arm_n_q, 32'b0}),
    .root_o (arm_root),
    .rem_o  (arm_rem)
  );

  arik_sqrt u_range_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .n_i    ({(SQRT_IN_W-40)'(0), range_n_q}),
    .root_o (range_root),
    .rem_o  (range_rem)
  );

  logic       sq_valid_q [SQRT_ROOT_W];
  arik_item_t sq_item_q  [SQRT_ROOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SQRT_ROOT_W; i++) begin
        sq_valid_q[i] <= 1'b0;
      end
    end else if (adv) begin
      sq_valid_q[0] <= m_valid_q;
      for (int i = 1; i < SQRT_ROOT_W; i++) begin
        sq_valid_q[i] <= sq_valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_item_q[0] <= m_item_q;
      for (int i = 1; i < SQRT_ROOT_W; i++) begin
        sq_item_q[i] <= sq_item_q[i-1];
      end
    end
  end

  // Reach, drive distance and the CORDIC vectors.
  arik_item_t          sq_item;
  logic [11:0]         arm_near;
  logic [20:0]         range_near;
  logic signed [12:0]  reach;
  logic signed [21:0]  drive_full;
  logic [19:0]         drive_sat;
  logic signed [CORDIC_W-1:0] d_vec, s_vec, x_vec, y_vec;

  assign sq_item = sq_item_q[SQRT_ROOT_W-1];
  // The root of n * 2^32 holds the root of n in its upper bits and the
  // half-unit rounding bit just below them.
  assign arm_near = {1'b0, arm_root[26:16]} + 12'(arm_root[15]);
  assign range_near = {1'b0, range_root[19:0]} +
                      21'(range_rem > {2'b0, range_root});
  assign reach = BASE_REACH + ((sq_item.region == REGION_BELOW) ?
                 {sq_item.d[11], sq_item.d} : $signed({1'b0, arm_near}));
  assign drive_full = $signed({1'b0, range_near}) - {{9{reach[12]}}, reach};

  always_comb begin
    if (drive_full > 22'sd524287) begin
      drive_sat = 20'h7FFFF;
    end else if (drive_full < -22'sd524288) begin
      drive_sat = 20'h80000;
    end else begin
      drive_sat = drive_full[19:0];
    end
  end

  assign d_vec = {{(CORDIC_W-28){sq_item.d[11]}}, sq_item.d, 16'b0};
  assign s_vec = $signed({{(CORDIC_W-SQRT_ROOT_W){1'b0}}, arm_root});
  assign x_vec = {{(CORDIC_W-36){sq_item.x[19]}}, sq_item.x, 16'b0};
  assign y_vec = {{(CORDIC_W-36){sq_item.y[19]}}, sq_item.y, 16'b0};

  logic signed [ANGLE_W-1:0] z_asin, z_acos, z_rot;

  arik_cordic #(.Steps(CordicSteps)) u_asin (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (s_vec),
    .y_i   (d_vec),
    .z_o   (z_asin)
  );

  arik_cordic #(.Steps(CordicSteps)) u_acos (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (d_vec),
    .y_i   (s_vec),
    .z_o   (z_acos)
  );

  arik_cordic #(.Steps(CordicSteps)) u_rot (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (x_vec),
    .y_i   (y_vec),
    .z_o   (z_rot)
  );

  logic       cd_valid_q [CordicSteps+1];
  arik_tail_t cd_tail_q  [CordicSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= CordicSteps; i++) begin
        cd_valid_q[i] <= 1'b0;
      end
    end else if (adv) begin
      cd_valid_q[0] <= sq_valid_q[SQRT_ROOT_W-1];
      for (int i = 1; i <= CordicSteps; i++) begin
        cd_valid_q[i] <= cd_valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cd_tail_q[0] <= '{status: sq_item.status, region: sq_item.region, drive: drive_sat};
      for (int i = 1; i <= CordicSteps; i++) begin
        cd_tail_q[i] <= cd_tail_q[i-1];
      end
    end
  end

  // Final angle selection.
  arik_tail_t  tail;
  logic [15:0] a_asin, a_acos, a_rot;
  logic [1:0]  region_d;
  logic [15:0] shoulder_d, elbow_d, wrist_d, rot_d;
  logic [19:0] drive_d;

  assign tail   = cd_tail_q[CordicSteps];
  assign a_asin = to_angle(z_asin);
  assign a_acos = to_angle(z_acos);
  assign a_rot  = to_angle(z_rot);

  always_comb begin
    region_d   = tail.region;
    shoulder_d = '0;
    elbow_d    = '0;
    wrist_d    = '0;
    rot_d      = a_rot;
    drive_d    = tail.drive;
    case (tail.region)
      REGION_ABOVE: begin
        elbow_d = a_asin;
        wrist_d = 16'd0 - a_asin;
      end
      REGION_MID: begin
        elbow_d = 16'd0 - a_asin;
        wrist_d = a_asin;
      end
      REGION_BELOW: begin
        shoulder_d = ShoulderAngle;
        elbow_d    = a_acos;
        wrist_d    = a_asin;
      end
      default: begin
        elbow_d = '0;
      end
    endcase
    // A rejected height reports only its status.
    if (tail.status != STATUS_OK) begin
      region_d   = '0;
      shoulder_d = '0;
      elbow_d    = '0;
      wrist_d    = '0;
      rot_d      = '0;
      drive_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cd_valid_q[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_o         <= tail.status;
      height_region_o  <= region_d;
      shoulder_angle_o <= shoulder_d;
      elbow_angle_o    <= elbow_d;
      wrist_angle_o    <= wrist_d;
      base_rotation_o  <= rot_d;
      drive_distance_o <= drive_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
